/* design/fbfl_pkg.sv */
// Shared types and constants for the fixed-block free-list allocator.
// No dependencies; imported by every module of the block.
package fbfl_pkg;

    localparam int ELEM_W    = 13;   // element / alignment register width
    localparam int SIZE_W    = 14;   // rounded element size, up to 2 * 8191
    localparam int SLOT_W    = 10;   // slot field width on the ports
    localparam int OFFS_W    = 23;   // byte offset field width
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_ELEM  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ALIGN = 2'd1;

    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;

    localparam logic STAT_OK      = 1'b0;
    localparam logic STAT_NOSPACE = 1'b1;

    localparam logic [ELEM_W-1:0] ELEM_RST  = 13'd8;
    localparam logic [ELEM_W-1:0] ALIGN_RST = 13'd8;

    // controller -> datapath
    typedef struct packed {
        logic clr_step;    // write one init entry of the link RAM
        logic accept;      // capture the input word
        logic exec_fire;   // apply the operation and load the result
        logic size_start;  // start the element size computation
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic clr_done;    // last init entry is being written
        logic out_free;    // output register can take a word this cycle
    } t_sts;

endpackage

/* design/fbfl_size.sv */
// Configuration registers and iterative element size unit.
// Depends on fbfl_pkg; one remainder bit per cycle while a run is busy.
module fbfl_size
    import fbfl_pkg::*;
#(
    parameter int MIN_ELEMENT_BYTES = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [ELEM_W-1:0]    i_cfg_data,
    input  logic                 i_start,
    output logic                 o_busy,
    output logic [SIZE_W-1:0]    o_size
);

    localparam int CNT_W = $clog2(ELEM_W + 1);

    logic [ELEM_W-1:0] r_elem;
    logic [ELEM_W-1:0] r_align;
    logic [ELEM_W-1:0] r_num;
    logic [ELEM_W-1:0] r_den;
    logic [ELEM_W-1:0] r_base;
    logic [ELEM_W-1:0] r_rem;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_busy;
    logic [SIZE_W-1:0] r_size;

    logic [ELEM_W-1:0] s_clamp;
    logic [ELEM_W-1:0] a_fixed;
    logic [ELEM_W:0]   rem_trial;
    logic [ELEM_W-1:0] n_rem;

    always_comb begin
        s_clamp = (r_elem < ELEM_W'(MIN_ELEMENT_BYTES)) ? ELEM_W'(MIN_ELEMENT_BYTES) : r_elem;
        a_fixed = (r_align == '0) ? ELEM_W'(1) : r_align;
        // shift in the next dividend bit, subtract when it fits
        rem_trial = {r_rem, r_num[ELEM_W-1]};
        if (rem_trial >= {1'b0, r_den}) begin
            n_rem = ELEM_W'(rem_trial - {1'b0, r_den});
        end else begin
            n_rem = rem_trial[ELEM_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_elem  <= ELEM_RST;
            r_align <= ALIGN_RST;
            r_busy  <= 1'b0;
            r_cnt   <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_ELEM:  r_elem  <= i_cfg_data;
                    CFG_ALIGN: r_align <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(ELEM_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num  <= s_clamp;
            r_base <= s_clamp;
            r_den  <= a_fixed;
            r_rem  <= '0;
        end else if (r_busy) begin
            r_num <= r_num << 1;
            r_rem <= n_rem;
            if (r_cnt == CNT_W'(1)) begin
                // round up to the next multiple of the alignment
                if (n_rem == '0) begin
                    r_size <= SIZE_W'(r_base);
                end else begin
                    r_size <= SIZE_W'(r_base) + SIZE_W'(r_den) - SIZE_W'(n_rem);
                end
            end
        end
    end

    assign o_busy = r_busy;
    assign o_size = r_size;

endmodule

/* design/fbfl_dp.sv */
// Datapath: link RAM, head pointer, offset multiplier and output register.
// Depends on fbfl_pkg; driven by fbfl_ctrl through t_cmd, reports t_sts.
module fbfl_dp
    import fbfl_pkg::*;
#(
    parameter int SLOTS = 1024
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_cmd,
    output t_sts              o_sts,
    input  logic              i_action,
    input  logic [SLOT_W-1:0] i_free_slot,
    input  logic [SIZE_W-1:0] i_size,
    input  logic              i_out_stall,
    output logic              o_out_valid,
    output logic              o_status,
    output logic [SLOT_W-1:0] o_slot_index,
    output logic [OFFS_W-1:0] o_byte_offset
);

    localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int PW = SW + SIZE_W;

    logic [SW:0]   r_mem [SLOTS];   // {valid, link}
    logic [SW:0]   r_rd;
    logic [SW-1:0] r_head;
    logic          r_head_v;
    logic [SW-1:0] r_clr;
    logic          r_act;
    logic [SLOT_W-1:0] r_slot;

    logic              r_out_valid;
    logic              r_status;
    logic [SLOT_W-1:0] r_slot_out;
    logic [OFFS_W-1:0] r_offs;

    logic [31:0]   slot_ext;
    logic [31:0]   head_ext;
    logic [SW-1:0] free_idx;
    logic          free_ok;
    logic          clr_last;
    logic [PW-1:0] prod;
    logic [31:0]   prod_ext;
    logic          do_free;
    logic          do_pop;

    always_comb begin
        slot_ext = 32'(r_slot);
        head_ext = 32'(r_head);
        free_idx = slot_ext[SW-1:0];
        free_ok  = slot_ext < 32'(SLOTS);
        clr_last = r_clr == SW'(SLOTS - 1);
        prod     = PW'(r_head) * PW'(i_size);
        prod_ext = 32'(prod);
        do_free  = i_cmd.exec_fire && (r_act == ACT_FREE) && free_ok;
        do_pop   = i_cmd.exec_fire && (r_act == ACT_ALLOC) && r_head_v;
    end

    // link RAM: one write port, one registered read at the head
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_step) begin
            r_mem[r_clr] <= {!clr_last, SW'(r_clr + SW'(1))};
        end else if (do_free) begin
            r_mem[free_idx] <= {r_head_v, r_head};
        end
        r_rd <= r_mem[r_head];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '0;
            r_head_v    <= 1'b1;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.clr_step && !clr_last) begin
                r_clr <= r_clr + SW'(1);
            end
            if (do_pop) begin
                r_head   <= r_rd[SW-1:0];
                r_head_v <= r_rd[SW];
            end else if (do_free) begin
                r_head   <= free_idx;
                r_head_v <= 1'b1;
            end
            if (i_cmd.exec_fire) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_act  <= i_action;
            r_slot <= i_free_slot;
        end
        if (i_cmd.exec_fire) begin
            if (do_pop) begin
                r_status   <= STAT_OK;
                r_slot_out <= head_ext[SLOT_W-1:0];
                r_offs     <= prod_ext[OFFS_W-1:0];
            end else begin
                r_status   <= (r_act == ACT_ALLOC) ? STAT_NOSPACE : STAT_OK;
                r_slot_out <= '0;
                r_offs     <= '0;
            end
        end
    end

    assign o_sts.clr_done = clr_last;
    assign o_sts.out_free = !r_out_valid || !i_out_stall;

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_status;
    assign o_slot_index  = r_slot_out;
    assign o_byte_offset = r_offs;

endmodule

/* design/fbfl_ctrl.sv */
// Controller: sequences RAM init, size computation and each operation.
// Depends on fbfl_pkg; drives t_cmd to fbfl_dp and the start of fbfl_size.
module fbfl_ctrl
    import fbfl_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  logic i_cfg_we,
    input  logic i_size_busy,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    localparam logic [2:0] ST_CLEAR     = 3'd0;
    localparam logic [2:0] ST_SIZE_GO   = 3'd1;
    localparam logic [2:0] ST_SIZE_WAIT = 3'd2;
    localparam logic [2:0] ST_IDLE      = 3'd3;
    localparam logic [2:0] ST_EXEC      = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       r_dirty;
    logic       n_dirty;
    logic       stall;

    always_comb begin
        stall   = (r_state != ST_IDLE) || r_dirty;
        n_state = r_state;
        n_dirty = r_dirty;
        o_cmd   = '0;
        unique case (r_state)
            ST_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_sts.clr_done) begin
                    n_state = ST_SIZE_GO;
                end
            end
            ST_SIZE_GO: begin
                o_cmd.size_start = 1'b1;
                n_dirty = 1'b0;
                n_state = ST_SIZE_WAIT;
            end
            ST_SIZE_WAIT: begin
                if (!i_size_busy) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (r_dirty) begin
                    n_state = ST_SIZE_GO;
                end else if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                // hold until the output register frees up
                if (i_sts.out_free) begin
                    o_cmd.exec_fire = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
        if (i_cfg_we) begin
            n_dirty = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_dirty <= 1'b0;
        end else begin
            r_state <= n_state;
            r_dirty <= n_dirty;
        end
    end

    assign o_in_stall = stall;

endmodule

/* design/fixed_block_free_list_allocator_top.sv */
// Channel   Direction  Handshake               Word
// in        input      i_in_valid / o_in_stall  i_action, i_free_slot
// out       output     o_out_valid / i_out_stall o_status, o_slot_index, o_byte_offset
// cfg       input      i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// For each word, the accept edge reads the head's next link from the synchronous
// link RAM; the firing edge updates the head and loads the result. No new word is taken meanwhile.
// After reset the link RAM is initialized one entry per cycle, followed by the
// element size computation; the input is stalled meanwhile.
// Every register write restarts the size computation, stalling the input until
// it completes. A stalled output holds the operation until the result register frees.
//
// Top level: ties controller, datapath and size unit together; uses fbfl_pkg.
module fixed_block_free_list_allocator_top
    import fbfl_pkg::*;
#(
    parameter int SLOTS             = 1024,
    parameter int MIN_ELEMENT_BYTES = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic                 i_action,
    input  logic [SLOT_W-1:0]    i_free_slot,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic                 o_status,
    output logic [SLOT_W-1:0]    o_slot_index,
    output logic [OFFS_W-1:0]    o_byte_offset,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [ELEM_W-1:0]    i_cfg_data
);

    t_cmd              cmd;
    t_sts              sts;
    logic              size_busy;
    logic [SIZE_W-1:0] size;
    logic              cfg_we;

    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid;

    fbfl_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_cfg_we    (cfg_we),
        .i_size_busy (size_busy),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    fbfl_size #(
        .MIN_ELEMENT_BYTES (MIN_ELEMENT_BYTES)
    ) u_size (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_start     (cmd.size_start),
        .o_busy      (size_busy),
        .o_size      (size)
    );

    fbfl_dp #(
        .SLOTS (SLOTS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_action      (i_action),
        .i_free_slot   (i_free_slot),
        .i_size        (size),
        .i_out_stall   (i_out_stall),
        .o_out_valid   (o_out_valid),
        .o_status      (o_status),
        .o_slot_index  (o_slot_index),
        .o_byte_offset (o_byte_offset)
    );

endmodule

/* bench/alloc_checker.sv */
// Scoreboard for the fixed-block free-list allocator: tracks the free list and
// element size, predicts every result word and compares it. Uses fbfl_pkg.
`timescale 1ns / 100ps

module alloc_checker
    import fbfl_pkg::*;
#(
    parameter int POOL_SLOTS = 1024,
    parameter int MIN_BYTES  = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_in_stall,
    input  logic                 i_action,
    input  logic [SLOT_W-1:0]    i_free_slot,
    input  logic                 i_out_valid,
    input  logic                 i_out_stall,
    input  logic                 i_status,
    input  logic [SLOT_W-1:0]    i_slot_index,
    input  logic [OFFS_W-1:0]    i_byte_offset,
    input  logic                 i_cfg_valid,
    input  logic                 i_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [ELEM_W-1:0]    i_cfg_data,
    output int                   o_pending,
    output int                   o_errors
);

    typedef struct packed {
        logic              status;
        logic [SLOT_W-1:0] slot;
        logic [OFFS_W-1:0] offset;
    } t_pool_word;

    logic [ELEM_W-1:0] req_bytes;
    logic [ELEM_W-1:0] align_bytes;
    logic [SLOT_W-1:0] head;
    logic              head_ok;
    logic [SLOT_W-1:0] link    [POOL_SLOTS];
    logic              link_ok [POOL_SLOTS];
    t_pool_word        due_q[$];
    int                err_count = 0;

    initial begin
        o_pending = 0;
        o_errors  = 0;
    end

    // Element size: raise to the minimum, then round up to the alignment.
    function automatic logic [SIZE_W-1:0] rounded_size(input logic [ELEM_W-1:0] req,
                                                       input logic [ELEM_W-1:0] align);
        int unsigned s;
        int unsigned a;
        s = (int'(req) < MIN_BYTES) ? MIN_BYTES : req;
        a = (align == '0) ? 1 : align;
        if (s % a != 0)
            s += a - s % a;
        return s[SIZE_W-1:0];
    endfunction

    // Apply one word to the free list and return the result it produces.
    function automatic t_pool_word pool_step(input logic act, input logic [SLOT_W-1:0] slot);
        t_pool_word  w;
        logic [63:0] prod;
        w = '0;
        if (act == ACT_ALLOC) begin
            if (!head_ok || int'(head) >= POOL_SLOTS) begin
                w.status = STAT_NOSPACE;
            end else begin
                w.status = STAT_OK;
                w.slot   = head;
                prod     = 64'(head) * 64'(rounded_size(req_bytes, align_bytes));
                w.offset = prod[OFFS_W-1:0];
                head_ok  = link_ok[head];
                head     = link[head];
            end
        end else if (int'(slot) < POOL_SLOTS) begin
            link[slot]    = head;
            link_ok[slot] = head_ok;
            head          = slot;
            head_ok       = 1'b1;
        end
        return w;
    endfunction

    function automatic void check_field(input string name, input longint want,
                                        input longint got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            err_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_pool_word want;
        if (!i_rst_n) begin
            req_bytes   = ELEM_RST;
            align_bytes = ALIGN_RST;
            for (int i = 0; i < POOL_SLOTS; i++) begin
                link[i]    = SLOT_W'(i + 1);
                link_ok[i] = (i + 1) < POOL_SLOTS;
            end
            head    = '0;
            head_ok = 1'b1;
            due_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == CFG_ELEM)
                    req_bytes = i_cfg_data;
                else if (i_cfg_index == CFG_ALIGN)
                    align_bytes = i_cfg_data;
            end
            // compare before pushing so a stray word is never matched to a fresh one
            if (i_out_valid && !i_out_stall) begin
                if (due_q.size() == 0) begin
                    $display("%0t: unexpected result word, expected none, actual %0d/%0d/%0d",
                             $time, i_status, i_slot_index, i_byte_offset);
                    err_count++;
                end else begin
                    want = due_q.pop_front();
                    check_field("status", want.status, i_status);
                    check_field("slot_index", want.slot, i_slot_index);
                    check_field("byte_offset", want.offset, i_byte_offset);
                end
            end
            if (i_in_valid && !i_in_stall)
                due_q.push_back(pool_step(i_action, i_free_slot));
        end
        o_pending <= due_q.size();
        o_errors  <= err_count;
    end

endmodule

/* bench/tb_top.sv */
// Top of the allocator testbench: clock, reset, stimulus and verdict.
// Depends on fbfl_pkg, fixed_block_free_list_allocator_top and alloc_checker.
`timescale 1ns / 100ps

module tb_top;
    import fbfl_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
    localparam int                   LIMIT     = 300000;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_stall;
    logic                 i_action;
    logic [SLOT_W-1:0]    i_free_slot;
    logic                 o_out_valid;
    logic                 i_out_stall;
    logic                 o_status;
    logic [SLOT_W-1:0]    o_slot_index;
    logic [OFFS_W-1:0]    o_byte_offset;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [ELEM_W-1:0]    i_cfg_data;

    int pending;
    int errors;
    int send_idle_pct = 0;
    int stall_pct     = 0;
    int cycle_count   = 0;

    fixed_block_free_list_allocator_top dut (.*);

    alloc_checker pool_watch (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_in_stall    (o_in_stall),
        .i_action      (i_action),
        .i_free_slot   (i_free_slot),
        .i_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .i_status      (o_status),
        .i_slot_index  (o_slot_index),
        .i_byte_offset (o_byte_offset),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_pending     (pending),
        .o_errors      (errors)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < stall_pct);
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Present one word, hold it until taken, then maybe leave a gap.
    task automatic send_word(input logic act, input logic [SLOT_W-1:0] slot);
        i_in_valid  <= 1'b1;
        i_action    <= act;
        i_free_slot <= slot;
        do @(posedge i_clk); while (o_in_stall);
        if ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
    endtask

    // Hold off input until every expected word has come back.
    task automatic drain();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [ELEM_W-1:0] data,
                             input bit last);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (last)
            i_cfg_valid <= 1'b0;
    endtask

    task automatic set_size(input logic [ELEM_W-1:0] req, input logic [ELEM_W-1:0] align);
        drain();
        cfg_write(CFG_ELEM, req, 1'b0);
        cfg_write(CFG_ALIGN, align, 1'b1);
    endtask

    initial begin
        int n_items[4]   = '{400, 330, 330, 290};
        int alloc_pct[4] = '{92, 85, 90, 95};
        int idle_set[4]  = '{0, 66, 0, 12};
        int stall_set[4] = '{0, 0, 66, 12};
        logic act;

        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_action    = ACT_ALLOC;
        i_free_slot = '0;
        i_out_stall = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_ELEM;
        i_cfg_data  = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset sizes; pop, push back low and high ends, double free
        send_word(ACT_ALLOC, '1);
        send_word(ACT_ALLOC, '0);
        send_word(ACT_FREE, '0);
        send_word(ACT_ALLOC, '0);
        send_word(ACT_FREE, 10'd1023);
        send_word(ACT_ALLOC, '0);
        send_word(ACT_FREE, 10'd5);
        send_word(ACT_FREE, 10'd5);
        send_word(ACT_ALLOC, '0);
        send_word(ACT_ALLOC, '0);
        send_word(ACT_FREE, 10'h2AA);
        send_word(ACT_FREE, 10'h155);
        send_word(ACT_ALLOC, 10'h3FF);
        send_word(ACT_ALLOC, 10'h2AA);

        // below the minimum size with zero alignment
        set_size('0, '0);
        send_word(ACT_ALLOC, '0);
        send_word(ACT_FREE, 10'd1023);
        send_word(ACT_ALLOC, '0);

        // largest size, offset wraps past its width
        set_size('1, 13'd8190);
        send_word(ACT_FREE, 10'd1023);
        send_word(ACT_ALLOC, '0);
        send_word(ACT_ALLOC, '0);

        // unknown index is dropped; largest alignment too
        drain();
        cfg_write(CFG_SPARE, 13'd77, 1'b0);
        cfg_write(CFG_ALIGN, '1, 1'b1);
        send_word(ACT_FREE, 10'd1000);
        send_word(ACT_ALLOC, '0);

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: set_size(13'd1, 13'd1);
                1: set_size('1, '1);
                2: set_size(ELEM_W'($urandom_range(4096, 1)),
                            ELEM_W'(1 << $urandom_range(12)));
                default: set_size(13'd4096, 13'd3000);
            endcase
            send_idle_pct = idle_set[ph];
            stall_pct     = stall_set[ph];
            for (int k = 0; k < n_items[ph]; k++) begin
                if (ph == 1 && k == 150)
                    drain();
                act = ($urandom_range(99) < alloc_pct[ph]) ? ACT_ALLOC : ACT_FREE;
                send_word(act, SLOT_W'($urandom_range(1023)));
            end
        end

        drain();
        repeat (20) @(posedge i_clk);
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

/* filelist.f */
design/fbfl_pkg.sv
design/fbfl_size.sv
design/fbfl_dp.sv
design/fbfl_ctrl.sv
design/fixed_block_free_list_allocator_top.sv
bench/alloc_checker.sv
bench/tb_top.sv
